// ===== rtl/core/multichannel_delay_line_top_macros.svh =====
// assertion macros for the multichannel delay line
`ifndef MULTICHANNEL_DELAY_LINE_TOP_MACROS_SVH
`define MULTICHANNEL_DELAY_LINE_TOP_MACROS_SVH

// same-cycle implication
`define MDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mdl_pkg.sv =====
// types and constants for the multichannel delay line
`timescale 1ns / 1ps

package mdl_pkg;

   localparam int CHANNELS_DEF    = 4;
   localparam int DEPTH_DEF       = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   localparam int CHAN_BITS      = 2;
   localparam int WORD_BITS      = 32;
   localparam int DELAY_BITS     = 10;
   localparam int MASK_BITS      = 4;
   localparam int NUM_DELAY_REGS = 4;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 10;

   typedef logic [CHAN_BITS-1:0]     chan_type;
   typedef logic [WORD_BITS-1:0]     word_type;
   typedef logic [DELAY_BITS-1:0]    delay_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   localparam csr_index_type CSR_DELAY_CH0 = 3'd0;
   localparam csr_index_type CSR_DELAY_CH1 = 3'd1;
   localparam csr_index_type CSR_DELAY_CH2 = 3'd2;
   localparam csr_index_type CSR_DELAY_CH3 = 3'd3;
   localparam csr_index_type CSR_BYPASS    = 3'd4;

endpackage

// ===== rtl/core/multichannel_delay_line_top.sv =====
// multichannel circular delay line: one ring per channel in a shared memory
//
//  channel | direction | tdata / data       | tuser / index
//  req_    | in        | sample_in          | channel
//  rsp_    | out       | sample_out         | out_channel
//  csr_    | in        | register value     | register index
//
// one sample is taken each cycle req_tready is high; s1, then s2 drives rsp_tvalid
// the ring memory has one write and one read port, used once per sample
// after reset all CHANNELS*DEPTH memory entries are swept to zero, req_tready low
// configuration writes are taken in every cycle, the sweep included
// a stalled rsp_ side holds the result and stops req_ once both stages are full
`timescale 1ns / 1ps

`include "multichannel_delay_line_top_macros.svh"

module multichannel_delay_line_top #(
   parameter int CHANNELS    = mdl_pkg::CHANNELS_DEF,
   parameter int DEPTH       = mdl_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = mdl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mdl_pkg::word_type     req_tdata,   // sample_in
   input  mdl_pkg::chan_type     req_tuser,   // channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mdl_pkg::word_type     rsp_tdata,   // sample_out
   output mdl_pkg::chan_type     rsp_tuser,   // out_channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  mdl_pkg::csr_index_type csr_index,
   input  mdl_pkg::csr_data_type csr_data
);
   import mdl_pkg::*;

   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int ENTRIES   = CHANNELS * DEPTH;
   localparam int ADDR_BITS = $clog2(ENTRIES);
   localparam int CMP_BITS  = (PTR_BITS > DELAY_BITS) ? PTR_BITS : DELAY_BITS;
   localparam logic [CMP_BITS-1:0]  DELAY_CAP  = CMP_BITS'(DEPTH - 1);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR  = ADDR_BITS'(ENTRIES - 1);

   logic [SAMPLE_BITS-1:0] ring_mem [0:ENTRIES-1];

   delay_type              delay_ff [0:NUM_DELAY_REGS-1];
   logic [MASK_BITS-1:0]   bypass_ff;
   logic [PTR_BITS-1:0]    wp_ff, wp_in;
   logic                   clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   logic                   s1_valid_ff, s1_valid_in;
   chan_type               s1_chan_ff;
   logic                   s1_hole_ff;
   logic                   s1_fwd_ff;
   logic [SAMPLE_BITS-1:0] s1_word_ff;

   logic                   s2_valid_ff, s2_valid_in;
   chan_type               s2_chan_ff;
   word_type               s2_data_ff;

   logic                   s2_free, s1_adv, req_fire;
   logic                   has_ring, is_last, bypass, fwd;
   logic [CMP_BITS-1:0]    delay_ext;
   logic [PTR_BITS-1:0]    eff_delay, rd_ptr;
   logic [SAMPLE_BITS-1:0] in_word, s1_sample;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_wdata;

   // handshakes
   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_tready = !reset && !clr_busy_ff && (!s1_valid_ff || s2_free);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // item decode
   always_comb begin
      in_word   = req_tdata[SAMPLE_BITS-1:0];
      has_ring  = 32'(req_tuser) < 32'(CHANNELS);
      is_last   = 32'(req_tuser) == 32'(CHANNELS - 1);
      bypass    = bypass_ff[req_tuser];
      delay_ext = CMP_BITS'(delay_ff[req_tuser]);
      eff_delay = (delay_ext > DELAY_CAP) ? PTR_BITS'(DELAY_CAP) : PTR_BITS'(delay_ext);
      fwd       = bypass || (eff_delay == '0);
      rd_ptr    = wp_ff - eff_delay;
   end

   // memory port selection
   always_comb begin
      mem_raddr = ADDR_BITS'({req_tuser, rd_ptr});
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = req_fire && has_ring;
         mem_waddr = ADDR_BITS'({req_tuser, wp_ff});
         mem_wdata = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   // next values of control state
   always_comb begin
      wp_in       = wp_ff;
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (req_fire && is_last) begin
         wp_in = wp_ff + PTR_BITS'(1);
      end
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
      s1_valid_in = req_fire || (s1_valid_ff && !s2_free);
      s2_valid_in = s1_adv || (s2_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DELAY_REGS; i++) begin
            delay_ff[i] <= '0;
         end
         bypass_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_DELAY_CH0, CSR_DELAY_CH1, CSR_DELAY_CH2, CSR_DELAY_CH3: begin
               delay_ff[csr_index[1:0]] <= csr_data;
            end
            CSR_BYPASS: begin
               bypass_ff <= csr_data[MASK_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read stage and output register
   always_comb begin
      if (s1_hole_ff) begin
         s1_sample = '0;
      end else if (s1_fwd_ff) begin
         s1_sample = s1_word_ff;
      end else begin
         s1_sample = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_chan_ff <= req_tuser;
         s1_hole_ff <= !has_ring;
         s1_fwd_ff  <= fwd;
         s1_word_ff <= in_word;
      end
      if (s1_adv) begin
         s2_chan_ff <= s1_chan_ff;
         s2_data_ff <= WORD_BITS'(s1_sample);
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_data_ff;
   assign rsp_tuser  = s2_chan_ff;

   `MDL_ASSERT_NEXT(a_wp_moves_on_last, clock, reset, !(req_fire && is_last),
                    wp_ff == $past(wp_ff),
                    "write pointer moved without a last-channel transfer")
   `MDL_ASSERT_NEXT(a_rd_held, clock, reset, s1_valid_ff && !s2_free,
                    $stable(rd_data_ff) && s1_valid_ff,
                    "read stage lost its data while stalled")
   `MDL_ASSERT_NOW(a_no_result_in_sweep, clock, reset, clr_busy_ff,
                   !s1_valid_ff && !s2_valid_ff && !req_fire,
                   "item in flight during memory sweep")

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the multichannel delay line top level
`timescale 1ns / 1ps

module tb_top;
   import mdl_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEF;
   localparam int NUM_CHAN   = CHANNELS_DEF;
   localparam int PTR_BITS   = $clog2(RING_DEPTH);
   localparam int STALL_LEN  = 300;
   localparam int DRAIN_LEN  = 16;

   typedef logic [PTR_BITS-1:0] ptr_type;

   typedef struct packed {
      chan_type channel;
      word_type sample;
   } sample_item_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   word_type      req_tdata = '0;
   chan_type      req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   word_type      rsp_tdata;
   chan_type      rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   csr_data_type  csr_data = '0;

   multichannel_delay_line_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_in
      .req_tuser  (req_tuser),   // channel
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out
      .rsp_tuser  (rsp_tuser),   // out_channel
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and scoreboard state
   sample_item_type pending_samples[$];
   sample_item_type expected_taps[$];
   int           offered_count  = 0;
   int           accepted_count = 0;
   int           result_count   = 0;
   int           csr_count      = 0;
   int           error_count    = 0;
   int           tx_idle_pct    = 33;
   int           rx_idle_pct    = 86;
   int           stall_requests = 0;
   int           stall_served   = 0;
   int           stall_left     = 0;
   sample_item_type next_item;
   sample_item_type got_item;
   sample_item_type seen_item;

   // model of the rings, pointer and registers
   word_type     ring_model[NUM_CHAN][RING_DEPTH];
   ptr_type      wptr_model;
   delay_type    delay_model[NUM_DELAY_REGS];
   logic [MASK_BITS-1:0] bypass_model;

   function automatic sample_item_type tap_sample(input sample_item_type in_item);
      sample_item_type tap;
      ptr_type      rd_ptr;
      int           dly;
      tap.channel = in_item.channel;
      tap.sample  = '0;
      if (int'(in_item.channel) < NUM_CHAN) begin
         ring_model[in_item.channel][wptr_model] = in_item.sample;
         dly = int'(delay_model[in_item.channel]);
         if (dly > RING_DEPTH - 1) begin
            dly = RING_DEPTH - 1;
         end
         if (bypass_model[in_item.channel]) begin
            rd_ptr = wptr_model;
         end else begin
            rd_ptr = wptr_model - ptr_type'(dly);
         end
         tap.sample = ring_model[in_item.channel][rd_ptr];
         if (int'(in_item.channel) == NUM_CHAN - 1) begin
            wptr_model = wptr_model + ptr_type'(1);
         end
      end
      return tap;
   endfunction

   // driver: req_ side
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && offered_count != accepted_count)) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            next_item = pending_samples.pop_front();
            req_tdata  <= next_item.sample;
            req_tuser  <= next_item.channel;
            req_tvalid <= 1'b1;
            offered_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: rsp_ side, with the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_requests != stall_served) begin
         stall_served++;
         stall_left = STALL_LEN;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // monitor: model update and result check
   always @(posedge clock) begin
      if (reset) begin
         foreach (ring_model[c, i]) begin
            ring_model[c][i] = '0;
         end
         foreach (delay_model[r]) begin
            delay_model[r] = '0;
         end
         wptr_model   = '0;
         bypass_model = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DELAY_CH0: delay_model[0] = csr_data;
               CSR_DELAY_CH1: delay_model[1] = csr_data;
               CSR_DELAY_CH2: delay_model[2] = csr_data;
               CSR_DELAY_CH3: delay_model[3] = csr_data;
               CSR_BYPASS:    bypass_model = csr_data[MASK_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            seen_item.channel = req_tuser;
            seen_item.sample  = req_tdata;
            expected_taps.push_back(tap_sample(seen_item));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_taps.size() == 0) begin
               $display("%0t: unexpected result ch %0d sample %h", $time,
                        rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               got_item = expected_taps.pop_front();
               if (rsp_tuser !== got_item.channel || rsp_tdata !== got_item.sample) begin
                  $display("%0t: mismatch expected ch %0d sample %h, actual ch %0d sample %h",
                           $time, got_item.channel, got_item.sample, rsp_tuser, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input csr_data_type val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_count++;
   endtask

   task automatic program_delays(input csr_data_type d0, input csr_data_type d1,
                                 input csr_data_type d2, input csr_data_type d3,
                                 input csr_data_type mask);
      write_reg(CSR_DELAY_CH0, d0);
      write_reg(CSR_DELAY_CH1, d1);
      write_reg(CSR_DELAY_CH2, d2);
      write_reg(CSR_DELAY_CH3, d3);
      write_reg(CSR_BYPASS, mask);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_samples.size() > 0 || offered_count != accepted_count ||
             expected_taps.size() > 0) begin
         @(posedge clock);
      end
   endtask

   function automatic word_type pick_sample();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic csr_data_type pick_delay();
      case ($urandom_range(7))
         0:       return '0;
         1:       return csr_data_type'(1);
         2:       return '1;
         3:       return csr_data_type'($urandom_range(1023));
         default: return csr_data_type'($urandom_range(40));
      endcase
   endfunction

   task automatic queue_frame(input word_type s0, input word_type s1,
                              input word_type s2, input word_type s3);
      pending_samples.push_back(sample_item_type'{channel: chan_type'(0), sample: s0});
      pending_samples.push_back(sample_item_type'{channel: chan_type'(1), sample: s1});
      pending_samples.push_back(sample_item_type'{channel: chan_type'(2), sample: s2});
      pending_samples.push_back(sample_item_type'{channel: chan_type'(3), sample: s3});
   endtask

   task automatic queue_random(input int count);
      int queued;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(99) < 85) begin
            queue_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            queued += 4;
         end else begin
            pending_samples.push_back(sample_item_type'{channel: chan_type'($urandom_range(3)),
                                                        sample: pick_sample()});
            queued++;
         end
      end
   endtask

   task automatic random_phase(input int count);
      program_delays(pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                     csr_data_type'($urandom_range(1023)));
      queue_random(count);
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero delay after reset
      tx_idle_pct = 33;
      rx_idle_pct = 86;
      queue_frame(32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      wait_idle();

      // one period, longest delay, two periods, none
      program_delays(10'd1, 10'h3FF, 10'd2, 10'd0, 10'h000);
      queue_frame(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h1234_5678);
      queue_frame(32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_frame(32'hAAAA_AAAA, 32'h5555_5555, 32'hDEAD_BEEF, 32'h0000_0000);
      wait_idle();

      // bypass on every channel, upper data bits set
      write_reg(CSR_BYPASS, 10'h3FF);
      @(negedge clock);
      csr_valid <= 1'b0;
      queue_frame(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0000, 32'hFFFF_FFFF);
      wait_idle();

      // unused register indexes must change nothing
      for (int k = 1; k <= 3; k++) begin
         write_reg(csr_index_type'(CSR_BYPASS + k), csr_data_type'($urandom_range(1023)));
      end
      program_delays(10'd3, 10'd3, 10'd3, 10'd3, 10'h005);
      queue_frame(32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
      wait_idle();

      // random phases, with a long receiver hold-off in the first and the last
      stall_requests++;
      random_phase(370);
      random_phase(370);
      tx_idle_pct = 86;
      rx_idle_pct = 33;
      random_phase(370);
      program_delays(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h000);
      queue_random(370);
      wait_idle();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      stall_requests++;
      random_phase(370);

      repeat (DRAIN_LEN) @(posedge clock);
      if (expected_taps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_taps.size());
         error_count++;
      end
      $display("run covered %0d samples, %0d results, %0d register writes, %0d errors",
               accepted_count, result_count, csr_count, error_count);
      $display("delays from zero to the ring depth, bypass masks and three idle profiles");
      if (error_count == 0) begin
         $display("** multichannel_delay_line_top: PASSED **");
      end else begin
         $display("** multichannel_delay_line_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("** multichannel_delay_line_top: FAILED **");
      $finish;
   end

endmodule
